@@ hw/rtl/gcrb_pkg.sv @@
`default_nettype none
package gcrb_pkg;

  // CORDIC iteration count and arctangent table in binary turns (2^32 = one circle)
  localparam int NITER = 30;
  localparam logic [31:0] ATAN_TAB [NITER] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // CORDIC start vector length (inverse gain, Q30)
  localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Degree to turn conversion: quotient of a biased dividend by 45
  localparam int DIV_W = 40;
  localparam int DIV_STAGES = 5;
  // ceil(2^46 / 45): multiply and keep bits from 46 up, exact for any 40-bit dividend
  localparam logic [40:0] DIV_RECIP = 41'd1563749870615;
  // 45 * 2^33 keeps the dividend positive, plus 22 for rounding
  localparam logic [DIV_W-1:0] TURN_BIAS = 40'h5A_0000_0016;

  // Square root and latency figures
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_LAT = SQRT_STEPS + 1;
  localparam int ATAN_LAT = NITER + 1;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] RADIUS_K = 31'd1416532188;
  localparam logic [29:0] DIST_MAX = 30'd708313088;
  localparam logic [24:0] BEARING_FULL = 25'd23592960;

  typedef enum logic [1:0] {
    REG_REF_LATITUDE  = 2'd0,
    REG_REF_LONGITUDE = 2'd1,
    REG_RANGE_LIMIT   = 2'd2
  } reg_index_t;

  // Q30 products floored back to Q30
  function automatic logic signed [33:0] mulq32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  function automatic logic signed [33:0] mulq34(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    return p[63:30];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/great_circle_range_bearing_gate.sv @@
`default_nettype none
// Great-circle range and bearing gate. Each input word carries a target
// latitude and longitude (degrees * 2^20); each output word carries the
// initial bearing from the configured reference point (degrees * 2^16,
// 0 up to 360), the haversine distance (NM * 2^16, saturating) and a flag
// set when the distance is not above range_limit. The block is a single
// pipeline that accepts one word per clock while the output is not stalled
// and returns results in order, through the turn dividers, the 30-stage
// sine/cosine CORDIC, the 31-stage square root and the 30-stage arctangent
// CORDIC. When the output word is not taken the whole pipeline holds.
// Configuration writes take effect at once and are meant for idle time.
module great_circle_range_bearing_gate (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // target_latitude [27:0], target_longitude [56:28]
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // bearing_deg [24:0], distance_nm [54:25], within_range [55]
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data
);

  localparam int SQL = gcrb_pkg::SQRT_LAT;
  localparam int ATL = gcrb_pkg::ATAN_LAT;

  logic signed [27:0] ref_latitude;
  logic signed [28:0] ref_longitude;
  logic [24:0]        range_limit;
  logic               en;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude <= 28'sd40894464;
      ref_longitude <= 29'sd37224448;
      range_limit <= 25'd32768000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcrb_pkg::REG_REF_LATITUDE:  ref_latitude <= cfg_data[27:0];
        gcrb_pkg::REG_REF_LONGITUDE: ref_longitude <= cfg_data;
        gcrb_pkg::REG_RANGE_LIMIT:   range_limit <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances while the output register is free or drained
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage: capture word, form differences
  logic               s0_valid;
  logic signed [27:0] s0_ref_lat;
  logic signed [27:0] s0_lat2;
  logic signed [28:0] s0_dlat;
  logic signed [29:0] s0_dlon;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ref_lat <= ref_latitude;
      s0_lat2 <= s_tdata[27:0];
      s0_dlat <= {s_tdata[27], s_tdata[27:0]} - {ref_latitude[27], ref_latitude};
      s0_dlon <= {s_tdata[56], s_tdata[56:28]} - {ref_longitude[28], ref_longitude};
    end
  end

  // Biased dividends for the degree to turn conversion
  logic [39:0] w_ref, w_lat2, w_dlon, w_hdlat, w_hdlon;
  assign w_ref   = {{3{s0_ref_lat[27]}}, s0_ref_lat, 9'd0} + gcrb_pkg::TURN_BIAS;
  assign w_lat2  = {{3{s0_lat2[27]}}, s0_lat2, 9'd0} + gcrb_pkg::TURN_BIAS;
  assign w_dlon  = {s0_dlon[29], s0_dlon, 9'd0} + gcrb_pkg::TURN_BIAS;
  assign w_hdlat = {{3{s0_dlat[28]}}, s0_dlat, 8'd0} + gcrb_pkg::TURN_BIAS;
  assign w_hdlon = {{2{s0_dlon[29]}}, s0_dlon, 8'd0} + gcrb_pkg::TURN_BIAS;

  logic        d_valid;
  logic [31:0] t_ref, t_lat2, t_dlon, t_hdlat, t_hdlon;

  gcrb_turn_div u_div_ref (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid), .dividend(w_ref),
    .out_valid(d_valid), .quotient(t_ref)
  );
  gcrb_turn_div u_div_lat2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid), .dividend(w_lat2),
    .out_valid(), .quotient(t_lat2)
  );
  gcrb_turn_div u_div_dlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid), .dividend(w_dlon),
    .out_valid(), .quotient(t_dlon)
  );
  gcrb_turn_div u_div_hdlat (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid), .dividend(w_hdlat),
    .out_valid(), .quotient(t_hdlat)
  );
  gcrb_turn_div u_div_hdlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid), .dividend(w_hdlon),
    .out_valid(), .quotient(t_hdlon)
  );

  // Sines and cosines
  logic               sc_valid;
  logic signed [31:0] s1, c1, s2, c2, sdl, cdl, shlat, shlon;

  gcrb_sincos u_sc_ref (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .angle(t_ref),
    .out_valid(sc_valid), .sin_q30(s1), .cos_q30(c1)
  );
  gcrb_sincos u_sc_lat2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .angle(t_lat2),
    .out_valid(), .sin_q30(s2), .cos_q30(c2)
  );
  gcrb_sincos u_sc_dlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .angle(t_dlon),
    .out_valid(), .sin_q30(sdl), .cos_q30(cdl)
  );
  gcrb_sincos u_sc_hdlat (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .angle(t_hdlat),
    .out_valid(), .sin_q30(shlat), .cos_q30()
  );
  gcrb_sincos u_sc_hdlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .angle(t_hdlon),
    .out_valid(), .sin_q30(shlon), .cos_q30()
  );

  // Product stages
  logic               p1_valid, p2_valid, p3_valid;
  logic signed [33:0] p1_yb, p1_m2, p1_m3, p1_m4, p1_m5, p1_m6;
  logic signed [31:0] p1_cdl;
  logic signed [33:0] p2_yb, p2_m2, p2_m4, p2_x3, p2_a2;
  logic signed [35:0] p3_xb, p3_yb;
  logic [30:0]        p3_a, p3_b;
  logic signed [35:0] xb_sum;
  logic signed [34:0] a_sum;
  logic [30:0]        a_clamp;

  assign xb_sum = {{2{p2_m2[33]}}, p2_m2} - {{2{p2_x3[33]}}, p2_x3};
  assign a_sum = {p2_m4[33], p2_m4} + {p2_a2[33], p2_a2};

  // Clamp the haversine term to [0, 1]
  always_comb begin
    if (a_sum[34]) begin
      a_clamp = '0;
    end else if (a_sum > $signed({4'd0, gcrb_pkg::Q30_ONE})) begin
      a_clamp = gcrb_pkg::Q30_ONE;
    end else begin
      a_clamp = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= sc_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_yb <= gcrb_pkg::mulq32(sdl, c2);
      p1_m2 <= gcrb_pkg::mulq32(c1, s2);
      p1_m3 <= gcrb_pkg::mulq32(s1, c2);
      p1_m4 <= gcrb_pkg::mulq32(shlat, shlat);
      p1_m5 <= gcrb_pkg::mulq32(c1, c2);
      p1_m6 <= gcrb_pkg::mulq32(shlon, shlon);
      p1_cdl <= cdl;
      p2_yb <= p1_yb;
      p2_m2 <= p1_m2;
      p2_m4 <= p1_m4;
      p2_x3 <= gcrb_pkg::mulq34(p1_m3, {{2{p1_cdl[31]}}, p1_cdl});
      p2_a2 <= gcrb_pkg::mulq34(p1_m5, p1_m6);
      p3_xb <= xb_sum;
      p3_yb <= {{2{p2_yb[33]}}, p2_yb};
      p3_a <= a_clamp;
      p3_b <= gcrb_pkg::Q30_ONE - a_clamp;
    end
  end

  // Square roots of a and 1 - a
  logic        sq_valid;
  logic [30:0] root_s, root_t;

  gcrb_isqrt u_sqrt_s (
    .clk(clk), .rst(rst), .en(en), .in_valid(p3_valid), .a(p3_a),
    .out_valid(sq_valid), .root(root_s)
  );
  gcrb_isqrt u_sqrt_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(p3_valid), .a(p3_b),
    .out_valid(), .root(root_t)
  );

  // Delay the bearing operands alongside the square roots
  logic signed [35:0] dly_xb [SQL];
  logic signed [35:0] dly_yb [SQL];
  logic               dly_zero [ATL];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_xb[0] <= p3_xb;
      dly_yb[0] <= p3_yb;
      for (int i = 1; i < SQL; i++) begin
        dly_xb[i] <= dly_xb[i-1];
        dly_yb[i] <= dly_yb[i-1];
      end
      dly_zero[0] <= (dly_xb[SQL-1] == '0) && (dly_yb[SQL-1] == '0);
      for (int i = 1; i < ATL; i++) begin
        dly_zero[i] <= dly_zero[i-1];
      end
    end
  end

  // Arctangents for bearing and central half angle
  logic        at_valid;
  logic [31:0] z_bear, z_dist;

  gcrb_atan2 u_atan_bear (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_valid),
    .y_in(dly_yb[SQL-1]), .x_in(dly_xb[SQL-1]),
    .out_valid(), .angle(z_bear)
  );
  gcrb_atan2 u_atan_dist (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_valid),
    .y_in({5'd0, root_s}), .x_in({5'd0, root_t}),
    .out_valid(at_valid), .angle(z_dist)
  );

  // Scale stage: bearing to degrees, central angle times radius
  logic        f1_valid;
  logic [37:0] f1_bprod;
  logic        f1_zero;
  logic [62:0] f1_dprod;
  logic [31:0] zc2;

  // Drop a negative half angle (CORDIC residue), then double it
  assign zc2 = z_dist[31] ? 32'd0 : {z_dist[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= at_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_bprod <= {6'd0, z_bear} * 38'd45 + 38'd4096;
      f1_zero <= dly_zero[ATL-1];
      f1_dprod <= 63'(zc2) * 63'(gcrb_pkg::RADIUS_K);
    end
  end

  // Output stage: round, saturate, gate
  logic [63:0] d_round;
  logic [31:0] dist_raw;
  logic [29:0] dist_sat;
  logic [24:0] bearing;
  logic [24:0] out_bearing;
  logic [29:0] out_distance;
  logic        out_within;

  assign d_round = {1'b0, f1_dprod} + 64'h8000_0000;
  assign dist_raw = d_round[63:32];
  assign dist_sat = (dist_raw > {2'd0, gcrb_pkg::DIST_MAX}) ? gcrb_pkg::DIST_MAX
                                                             : dist_raw[29:0];
  assign bearing = (f1_zero || (f1_bprod[37:13] >= gcrb_pkg::BEARING_FULL)) ? 25'd0
                                                                           : f1_bprod[37:13];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bearing <= bearing;
      out_distance <= dist_sat;
      out_within <= (dist_sat <= {5'd0, range_limit});
    end
  end

  assign m_tdata = {out_within, out_distance, out_bearing};

  // Gate flag agrees with the distance it was derived from
  a_gate_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55] == (m_tdata[54:25] <= {5'd0, range_limit})))
    else $error("within_range disagrees with distance_nm");

  // Bearing stays below a full circle
  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[24:0] < gcrb_pkg::BEARING_FULL))
    else $error("bearing_deg at or above full circle");

  // Distance never exceeds its saturation value
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[54:25] <= gcrb_pkg::DIST_MAX))
    else $error("distance_nm above saturation value");

  // A stalled output freezes the pipeline, so no word is accepted
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

endmodule
`default_nettype wire

@@ hw/rtl/gcrb_turn_div.sv @@
`default_nettype none
module gcrb_turn_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [39:0] dividend,
  output logic             out_valid,
  output logic [31:0]      quotient
);

  localparam int STAGES = gcrb_pkg::DIV_STAGES;
  localparam logic [40:0] RECIP = gcrb_pkg::DIV_RECIP;

  logic [40:0]       pp_ll;
  logic [39:0]       pp_lh;
  logic [40:0]       pp_hl;
  logic [39:0]       pp_hh;
  logic [41:0]       mid;
  logic [40:0]       lo;
  logic [39:0]       hh2;
  logic [61:0]       low_sum;
  logic [39:0]       hh3;
  logic [80:0]       total;
  logic [31:0]       q;
  logic [STAGES-1:0] vld;

  // Join the high partial product with the low sum
  assign total = {hh3, 41'd0} + {19'd0, low_sum};

  // Multiply the dividend in 20-bit pieces by the reciprocal of 45, then sum through mid, low_sum and q
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= 41'(dividend[19:0]) * 41'(RECIP[20:0]);
      pp_lh <= 40'(dividend[19:0]) * 40'(RECIP[40:21]);
      pp_hl <= 41'(dividend[39:20]) * 41'(RECIP[20:0]);
      pp_hh <= 40'(dividend[39:20]) * 40'(RECIP[40:21]);
      mid <= {1'b0, pp_lh, 1'b0} + {1'b0, pp_hl};
      lo <= pp_ll;
      hh2 <= pp_hh;
      low_sum <= {mid, 20'd0} + {21'd0, lo};
      hh3 <= hh2;
      q <= total[77:46];
      quotient <= q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

@@ hw/rtl/gcrb_sincos.sv @@
`default_nettype none
module gcrb_sincos (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [31:0]        angle,
  output logic                    out_valid,
  output logic signed [31:0]      sin_q30,
  output logic signed [31:0]      cos_q30
);

  localparam int N = gcrb_pkg::NITER;

  logic signed [33:0] x [N+1];
  logic signed [33:0] y [N+1];
  logic signed [33:0] z [N+1];
  logic               neg [N+1];
  logic [N+1:0]       vld;
  logic [31:0]        shifted;
  logic               fold;
  logic [31:0]        folded;

  // Fold the angle into the right half plane
  assign shifted = angle + 32'h4000_0000;
  assign fold = shifted[31];
  assign folded = fold ? (angle ^ gcrb_pkg::HALF_TURN) : angle;

  // Rotation stages, one iteration each
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= gcrb_pkg::CORDIC_KINV;
      y[0] <= '0;
      z[0] <= {{2{folded[31]}}, folded};
      neg[0] <= fold;
      for (int i = 0; i < N; i++) begin
        if (!z[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed({2'b00, gcrb_pkg::ATAN_TAB[i]});
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed({2'b00, gcrb_pkg::ATAN_TAB[i]});
        end
        neg[i+1] <= neg[i];
      end
      sin_q30 <= neg[N] ? 32'(-y[N]) : 32'(y[N]);
      cos_q30 <= neg[N] ? 32'(-x[N]) : 32'(x[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N:0], in_valid};
    end
  end

  assign out_valid = vld[N+1];

endmodule
`default_nettype wire

@@ hw/rtl/gcrb_isqrt.sv @@
`default_nettype none
module gcrb_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [30:0] a,
  output logic             out_valid,
  output logic [30:0]      root
);

  localparam int S = gcrb_pkg::SQRT_STEPS;

  logic [60:0] nrem [S+1];
  logic [60:0] res [S+1];
  logic [61:0] trial [S];
  logic [S:0]  vld;

  // Trial value of each step: partial root plus the current bit
  always_comb begin
    for (int i = 0; i < S; i++) begin
      trial[i] = {1'b0, res[i]} + (62'd1 << (60 - 2 * i));
    end
  end

  // Square root of a * 2^30, one result bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      nrem[0] <= {a, 30'd0};
      res[0] <= '0;
      for (int i = 0; i < S; i++) begin
        if ({1'b0, nrem[i]} >= trial[i]) begin
          nrem[i+1] <= nrem[i] - trial[i][60:0];
          res[i+1] <= (res[i] >> 1) + (61'd1 << (60 - 2 * i));
        end else begin
          nrem[i+1] <= nrem[i];
          res[i+1] <= res[i] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S-1:0], in_valid};
    end
  end

  assign out_valid = vld[S];
  assign root = res[S][30:0];

endmodule
`default_nettype wire

@@ hw/rtl/gcrb_atan2.sv @@
`default_nettype none
module gcrb_atan2 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [35:0] y_in,
  input  wire logic signed [35:0] x_in,
  output logic                    out_valid,
  output logic [31:0]             angle
);

  localparam int N = gcrb_pkg::NITER;

  logic signed [35:0] x [N+1];
  logic signed [35:0] y [N+1];
  logic [31:0]        z [N+1];
  logic [N:0]         vld;

  // Vectoring stages: fold to x >= 0, then drive y toward zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[35]) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= gcrb_pkg::HALF_TURN;
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
      for (int i = 0; i < N; i++) begin
        if (!y[i][35]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + gcrb_pkg::ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - gcrb_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-1:0], in_valid};
    end
  end

  assign out_valid = vld[N];
  assign angle = z[N];

endmodule
`default_nettype wire
